// ===== design/vad_pkg.sv =====
package vad_pkg;

    // request kinds carried in s_tuser
    localparam logic [1:0] REQ_BOOK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_BYTE  = 2'd2;

    // history source on a start request
    localparam logic [1:0] HIST_ZERO  = 2'd0;
    localparam logic [1:0] HIST_LOOP  = 2'd1;
    localparam logic [1:0] HIST_GIVEN = 2'd2;

    // register map, selected by paddr[2]
    localparam logic REG_LOOP_NEWEST = 1'b0;
    localparam logic REG_LOOP_OLDER  = 1'b1;

    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 36;
    localparam int FRAC_W   = 11;

    localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] SAT_MIN = 16'h8000;

    // per-lane control from the sequencer
    typedef struct packed {
        logic init;
        logic mac;
    } lane_ctrl_t;

endpackage

// ===== design/vad_coef_mem.sv =====
module vad_coef_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [15:0]   rd_data_a,
    output logic [15:0]   rd_data_b
);
    logic [15:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== design/vad_lane.sv =====
module vad_lane (
    input  logic                     aclk,
    input  vad_pkg::lane_ctrl_t      ctrl,
    input  logic [15:0]              init_res,
    input  logic [15:0]              coef,
    input  logic [15:0]              operand,
    output logic [15:0]              sample
);
    import vad_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [31:0]      prod;
    logic             fits;

    assign prod = 32'($signed(coef) * $signed(operand));

    // residual times 2048 seeds the sum, then one product a cycle while mac is high
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.init) begin
            acc_next = {{(ACC_W-SAMPLE_W-FRAC_W){init_res[15]}}, init_res, {FRAC_W{1'b0}}};
        end else if (ctrl.mac) begin
            acc_next = acc_reg + {{(ACC_W-32){prod[31]}}, prod};
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // floor shift right 11 and saturate to 16 bits
    assign fits = (acc_reg[ACC_W-1:FRAC_W+SAMPLE_W-1] == '0) ||
                  (acc_reg[ACC_W-1:FRAC_W+SAMPLE_W-1] == '1);

    always_comb begin
        if (fits) begin
            sample = acc_reg[FRAC_W+SAMPLE_W-1:FRAC_W];
        end else if (acc_reg[ACC_W-1]) begin
            sample = SAT_MIN;
        end else begin
            sample = SAT_MAX;
        end
    end

endmodule

// ===== design/vadpcm_frame_decoder.sv =====
// channel  | ports              | request contents
// ---------+--------------------+-------------------------------------------
// input    | s_tvalid/s_tready  | s_tuser req_type, s_tdata fields below
// output   | m_tvalid/m_tready  | m_tdata two samples, m_tlast end of frame
// config   | apb psel..prdata   | loop history registers at 0x0 and 0x4
//
// codebook writes, starts and header bytes are complete when accepted.
// a data byte for samples 2s, 2s+1 of its group passes run, drain and fin:
// each lane adds one product per cycle, both fed by the two-port codebook.
// the output register holds a finished pair while the next request is taken;
// requests wait while a byte decodes and while its pair awaits the output.
// aresetn is synchronous and clears history, frame position and valids;
// the codebook is not cleared.
module vadpcm_frame_decoder #(
    parameter int PREDICTORS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    // [6:0] coef_index, [22:7] coef_value, [24:23] hist_mode,
    // [40:25] given_newest, [56:41] given_older, [64:57] data_byte
    input  logic [71:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    // decoded pairs
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] sample_first, [31:16] sample_second
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vad_pkg::*;

    localparam int BOOK_WORDS = PREDICTORS * 16;
    localparam int BOOK_W     = $clog2(BOOK_WORDS);
    localparam int PRED_W     = (PREDICTORS > 1) ? $clog2(PREDICTORS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    // request fields
    logic [6:0]  coef_index;
    logic [15:0] coef_value;
    logic [1:0]  hist_mode;
    logic [15:0] given_newest;
    logic [15:0] given_older;
    logic [7:0]  data_byte;

    assign coef_index   = s_tdata[6:0];
    assign coef_value   = s_tdata[22:7];
    assign hist_mode    = s_tdata[24:23];
    assign given_newest = s_tdata[40:25];
    assign given_older  = s_tdata[56:41];
    assign data_byte    = s_tdata[64:57];

    logic [1:0]        state_reg, state_next;
    logic [15:0]       loop_newest_reg, loop_older_reg;
    logic [15:0]       hist_newest_reg, hist_older_reg;
    logic [15:0]       group_newest_reg, group_older_reg;
    logic [15:0]       resid_reg [8];
    logic [3:0]        scale_reg;
    logic [PRED_W-1:0] pred_reg;
    logic [3:0]        pos_reg;
    logic [2:0]        slot_reg;
    logic [3:0]        step_reg;
    logic              last_reg;
    logic              iss0_reg, iss1_reg;
    logic [15:0]       op_reg;
    logic              out_vld_reg;
    logic [31:0]       out_data_reg;
    logic              out_last_reg;

    logic              accept;
    logic              byte_go;
    logic [2:0]        slot_in;
    logic [15:0]       res_hi, res_lo;
    logic              out_free;
    logic              step_end;
    logic [3:0]        off0, off1;
    logic [2:0]        j1;
    logic [BOOK_W-1:0] rd_addr0, rd_addr1;
    logic [15:0]       coef0, coef1;
    logic [15:0]       op_sel;
    logic              book_wr;
    lane_ctrl_t        ctrl0, ctrl1;
    logic [15:0]       sample0, sample1;

    // predictor nibble wrapped to 3 bits, then reduced by the predictor count
    function automatic logic [PRED_W-1:0] wrap_pred(input logic [2:0] v);
        logic [4:0] m;
        m = {2'b00, v};
        for (int i = 0; i < 8; i++) begin
            if (m >= 5'(PREDICTORS)) begin
                m = m - 5'(PREDICTORS);
            end
        end
        return PRED_W'(m);
    endfunction

    // signed code shifted by the scale, wrapped to 16 bits
    function automatic logic [15:0] make_res(input logic [3:0] nib, input logic [3:0] sc);
        logic [15:0] ext;
        ext = {{12{nib[3]}}, nib};
        return ext << sc;
    endfunction

    function automatic logic [BOOK_W-1:0] book_addr(input logic [PRED_W-1:0] p,
                                                    input logic [3:0] off);
        return BOOK_W'({p, off});
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign byte_go  = accept && (s_tuser == REQ_BYTE) && (pos_reg != 4'd0);
    assign slot_in  = {pos_reg[1:0] - 2'd1, 1'b0};
    assign res_hi   = make_res(data_byte[7:4], scale_reg);
    assign res_lo   = make_res(data_byte[3:0], scale_reg);
    assign out_free = !out_vld_reg || m_tready;
    assign step_end = (step_reg == ({1'b0, slot_reg} + 4'd2));
    assign book_wr  = accept && (s_tuser == REQ_BOOK) &&
                      ({2'b00, coef_index} < 9'(BOOK_WORDS));

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (byte_go) state_next = ST_RUN;
            ST_RUN:   if (step_end) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // coefficient offsets: older tap, newest tap, then the residual filter taps
    assign j1 = slot_reg | 3'd1;
    always_comb begin
        if (step_reg == 4'd0) begin
            off0 = {1'b0, slot_reg};
            off1 = {1'b0, j1};
        end else if (step_reg == 4'd1) begin
            off0 = 4'd8 + {1'b0, slot_reg};
            off1 = 4'd8 + {1'b0, j1};
        end else begin
            off0 = 4'd9 + {1'b0, slot_reg} - step_reg;
            off1 = 4'd9 + {1'b0, j1} - step_reg;
        end
    end
    assign rd_addr0 = book_addr(pred_reg, off0);
    assign rd_addr1 = book_addr(pred_reg, off1);

    // shared operand for both lanes
    always_comb begin
        if (step_reg == 4'd0) begin
            op_sel = group_older_reg;
        end else if (step_reg == 4'd1) begin
            op_sel = group_newest_reg;
        end else begin
            op_sel = resid_reg[3'(step_reg - 4'd2)];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            hist_newest_reg  <= '0;
            hist_older_reg   <= '0;
            group_newest_reg <= '0;
            group_older_reg  <= '0;
            scale_reg        <= '0;
            pred_reg         <= '0;
            pos_reg          <= '0;
            loop_newest_reg  <= '0;
            loop_older_reg   <= '0;
            out_vld_reg      <= 1'b0;
            iss0_reg         <= 1'b0;
            iss1_reg         <= 1'b0;
            step_reg         <= '0;
        end else begin
            state_reg <= state_next;
            iss0_reg  <= (state_reg == ST_RUN) && !step_end;
            iss1_reg  <= (state_reg == ST_RUN);

            // register writes
            if (psel && penable && pwrite && pready) begin
                unique case (paddr[2])
                    REG_LOOP_NEWEST: loop_newest_reg <= pwdata[15:0];
                    REG_LOOP_OLDER:  loop_older_reg  <= pwdata[15:0];
                    default: ;
                endcase
            end

            // step counter
            if (byte_go) begin
                step_reg <= '0;
            end else if (state_reg == ST_RUN) begin
                step_reg <= step_reg + 4'd1;
            end

            // request decode
            if (accept) begin
                unique case (s_tuser)
                    REQ_START: begin
                        pos_reg <= '0;
                        unique case (hist_mode)
                            HIST_LOOP: begin
                                hist_newest_reg <= loop_newest_reg;
                                hist_older_reg  <= loop_older_reg;
                            end
                            HIST_GIVEN: begin
                                hist_newest_reg <= given_newest;
                                hist_older_reg  <= given_older;
                            end
                            default: begin
                                hist_newest_reg <= '0;
                                hist_older_reg  <= '0;
                            end
                        endcase
                    end
                    REQ_BYTE: begin
                        if (pos_reg == 4'd0) begin
                            scale_reg <= data_byte[7:4];
                            pred_reg  <= wrap_pred(data_byte[2:0]);
                            pos_reg   <= 4'd1;
                        end else begin
                            pos_reg <= (pos_reg >= 4'd8) ? 4'd0 : pos_reg + 4'd1;
                            if (slot_in == 3'd0) begin
                                group_newest_reg <= hist_newest_reg;
                                group_older_reg  <= hist_older_reg;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            // merge the lanes into the output register
            if (state_reg == ST_FIN && out_free) begin
                out_vld_reg     <= 1'b1;
                hist_older_reg  <= sample0;
                hist_newest_reg <= sample1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg <= op_sel;
        if (byte_go) begin
            slot_reg                 <= slot_in;
            last_reg                 <= (pos_reg >= 4'd8);
            resid_reg[slot_in]       <= res_hi;
            resid_reg[slot_in | 3'd1] <= res_lo;
        end
        if (state_reg == ST_FIN && out_free) begin
            out_data_reg <= {sample1, sample0};
            out_last_reg <= last_reg;
        end
    end

    vad_coef_mem #(
        .DEPTH (BOOK_WORDS),
        .AW    (BOOK_W)
    ) u_book (
        .aclk      (aclk),
        .wr_en     (book_wr),
        .wr_addr   (BOOK_W'(coef_index)),
        .wr_data   (coef_value),
        .rd_addr_a (rd_addr0),
        .rd_addr_b (rd_addr1),
        .rd_data_a (coef0),
        .rd_data_b (coef1)
    );

    assign ctrl0.init = byte_go;
    assign ctrl0.mac  = iss0_reg;
    assign ctrl1.init = byte_go;
    assign ctrl1.mac  = iss1_reg;

    // lane for the high nibble sample
    vad_lane u_lane0 (
        .aclk     (aclk),
        .ctrl     (ctrl0),
        .init_res (res_hi),
        .coef     (coef0),
        .operand  (op_reg),
        .sample   (sample0)
    );

    // lane for the low nibble sample
    vad_lane u_lane1 (
        .aclk     (aclk),
        .ctrl     (ctrl1),
        .init_res (res_lo),
        .coef     (coef1),
        .operand  (op_reg),
        .sample   (sample1)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // register read back
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            REG_LOOP_NEWEST: prdata = {{16{loop_newest_reg[15]}}, loop_newest_reg};
            REG_LOOP_OLDER:  prdata = {{16{loop_older_reg[15]}}, loop_older_reg};
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== design/vadpcm_frame_decoder_checker.sv =====
module vadpcm_frame_decoder_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        pready
);
    import vad_pkg::*;

    // a stalled pair holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output pair changed while stalled");

    // only a data byte can make a pair appear
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != REQ_BYTE |=> !$rose(m_tvalid))
        else $error("pair appeared after a non-data request");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // the register port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind vadpcm_frame_decoder vadpcm_frame_decoder_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

// ===== verif/tb_vadpcm_frame_decoder.sv =====
`timescale 1ns / 100ps

module tb_vadpcm_frame_decoder;
    import vad_pkg::*;

    localparam int N_PRED      = 8;
    localparam int BOOK_WORDS  = N_PRED * 16;
    localparam int DRAIN       = 40;
    localparam int LIMIT       = 400000;
    localparam int PHASE_ITEMS = 160;
    localparam int HOLD_CYCLES = 250;

    // codes the package leaves out: the spare request kind and history source
    localparam logic [1:0] REQ_SPARE  = 2'd3;
    localparam logic [1:0] HIST_SPARE = 2'd3;

    localparam logic [2:0] ADDR_NEWEST = {REG_LOOP_NEWEST, 2'b00};
    localparam logic [2:0] ADDR_OLDER  = {REG_LOOP_OLDER, 2'b00};

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  idx;
        logic [15:0] coef;
        logic [1:0]  mode;
        logic [15:0] gnew;
        logic [15:0] gold;
        logic [7:0]  data;
    } vad_req_t;

    typedef struct packed {
        logic [15:0] first_s;
        logic [15:0] second_s;
        logic        frame_end;
    } pair_t;

    typedef struct packed {
        vad_req_t req;
        logic     typed;
        pair_t    want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // testbench control
    logic        idle_on   = 1'b1;
    logic        hold_arm  = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          cycle_count = 0;
    int          err_count = 0;
    pair_t       pending_pairs[$];
    dir_row_t    dir_rows[$];
    pair_t       mon_want;

    // decoder state as predicted
    logic signed [15:0] book_words [BOOK_WORDS];
    logic signed [15:0] res_words [8];
    logic signed [15:0] loop_newest_q = '0;
    logic signed [15:0] loop_older_q  = '0;
    logic signed [15:0] hist_newest_q = '0;
    logic signed [15:0] hist_older_q  = '0;
    logic signed [15:0] grp_newest_q  = '0;
    logic signed [15:0] grp_older_q   = '0;
    logic [3:0]         scale_q       = '0;
    logic [2:0]         predsel_q     = '0;
    logic [3:0]         pos_q         = '0;

    vadpcm_frame_decoder #(
        .PREDICTORS(N_PRED)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic void check_field(input string name, input int exp, input int act);
        if (exp != act) begin
            err_count++;
            $error("%s: expected %0d, got %0d", name, exp, act);
        end
    endfunction

    // residual code scaled and wrapped to 16 bits
    function automatic logic signed [15:0] scale_code(input logic [3:0] nib);
        logic signed [31:0] code;
        logic [31:0]        wide;
        code = {{28{nib[3]}}, nib};
        wide = code << scale_q;
        return wide[15:0];
    endfunction

    // second-order prediction plus residual filter for sample j of the group
    function automatic logic signed [15:0] sample_at(input int j);
        int     base;
        longint acc;
        base = int'(predsel_q) * 16;
        acc = longint'(book_words[base + j]) * longint'(grp_older_q)
            + longint'(book_words[base + 8 + j]) * longint'(grp_newest_q)
            + longint'(res_words[j]) * 2048;
        for (int k = 0; k < j; k++)
            acc += longint'(book_words[base + 8 + (j - k - 1)]) * longint'(res_words[k]);
        acc = acc >>> FRAC_W;
        if (acc > 32767)
            return SAT_MAX;
        if (acc < -32768)
            return SAT_MIN;
        return 16'(acc);
    endfunction

    // advance the predicted state by one request, returns 1 with a pair
    function automatic bit decode_request(input vad_req_t r, output pair_t p);
        int                 slot;
        logic signed [15:0] s0;
        logic signed [15:0] s1;
        bit                 fe;
        p = '0;
        case (r.kind)
            REQ_BOOK: begin
                if (int'(r.idx) < BOOK_WORDS)
                    book_words[r.idx] = r.coef;
                return 1'b0;
            end
            REQ_START: begin
                case (r.mode)
                    HIST_LOOP: begin
                        hist_newest_q = loop_newest_q;
                        hist_older_q  = loop_older_q;
                    end
                    HIST_GIVEN: begin
                        hist_newest_q = r.gnew;
                        hist_older_q  = r.gold;
                    end
                    default: begin
                        hist_newest_q = '0;
                        hist_older_q  = '0;
                    end
                endcase
                pos_q = '0;
                return 1'b0;
            end
            REQ_BYTE: begin
                if (pos_q == 0) begin
                    scale_q   = r.data[7:4];
                    predsel_q = 3'(int'(r.data[2:0]) % N_PRED);
                    pos_q     = 4'd1;
                    return 1'b0;
                end
                slot = ((int'(pos_q) - 1) & 3) * 2;
                if (slot == 0) begin
                    grp_newest_q = hist_newest_q;
                    grp_older_q  = hist_older_q;
                end
                res_words[slot]     = scale_code(r.data[7:4]);
                res_words[slot + 1] = scale_code(r.data[3:0]);
                s0 = sample_at(slot);
                s1 = sample_at(slot + 1);
                hist_older_q  = s0;
                hist_newest_q = s1;
                fe = (pos_q >= 8);
                pos_q = fe ? 4'd0 : pos_q + 4'd1;
                p.first_s   = s0;
                p.second_s  = s1;
                p.frame_end = fe;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // all fields random, kind fixed
    function automatic vad_req_t rand_req(input logic [1:0] kind);
        vad_req_t r;
        r.kind = kind;
        r.idx  = 7'($urandom);
        r.coef = 16'($urandom);
        r.mode = 2'($urandom);
        r.gnew = 16'($urandom);
        r.gold = 16'($urandom);
        r.data = 8'($urandom);
        return r;
    endfunction

    // directed row: f1..f3 carry index/value, mode/history or the byte
    function automatic void add_row(input logic [1:0] kind, input logic [15:0] f1,
                                    input logic [15:0] f2, input logic [15:0] f3,
                                    input bit typed, input logic [15:0] e0,
                                    input logic [15:0] e1, input bit el);
        dir_row_t d;
        d.req = rand_req(kind);
        case (kind)
            REQ_BOOK: begin
                d.req.idx  = f1[6:0];
                d.req.coef = f2;
            end
            REQ_START: begin
                d.req.mode = f1[1:0];
                d.req.gnew = f2;
                d.req.gold = f3;
            end
            REQ_BYTE: d.req.data = f1[7:0];
            default: ;
        endcase
        d.typed          = typed;
        d.want.first_s   = e0;
        d.want.second_s  = e1;
        d.want.frame_end = el;
        dir_rows.push_back(d);
    endfunction

    // offer one request, predict once it is taken
    task automatic push_request(input vad_req_t r, input bit typed, input pair_t want);
        pair_t p;
        while (idle_on && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {7'd0, r.data, r.gold, r.gnew, r.mode, r.coef, r.idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (decode_request(r, p))
            pending_pairs.push_back(typed ? want : p);
    endtask

    task automatic drain_pairs();
        s_tvalid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {{16{value[15]}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr[2] == REG_LOOP_NEWEST)
            loop_newest_q = value;
        else
            loop_older_q = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [2:0] addr, input logic [15:0] exp);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        check_field("prdata", int'($signed(exp)), int'($signed(prdata[15:0])));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_loop(input logic [15:0] newest, input logic [15:0] older);
        apb_write(ADDR_NEWEST, newest);
        apb_write(ADDR_OLDER, older);
        apb_read(ADDR_NEWEST, newest);
        apb_read(ADDR_OLDER, older);
    endtask

    // mostly whole frames with random content, some noise and cut frames
    task automatic run_random(input int n_items);
        int       done;
        int       pick;
        int       nbytes;
        vad_req_t r;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                if ($urandom_range(9) != 0) begin
                    r = rand_req(REQ_START);
                    if ($urandom_range(9) == 0)
                        r.mode = HIST_SPARE;
                    else
                        r.mode = 2'($urandom_range(2));
                    push_request(r, 1'b0, '0);
                    done++;
                end
                r = rand_req(REQ_BYTE);
                if ($urandom_range(1))
                    r.data[7:4] = 4'($urandom_range(6));
                push_request(r, 1'b0, '0);
                done++;
                nbytes = ($urandom_range(9) == 0) ? $urandom_range(7) : 8;
                repeat (nbytes) begin
                    push_request(rand_req(REQ_BYTE), 1'b0, '0);
                    done++;
                end
            end else if (pick < 80) begin
                repeat ($urandom_range(4, 1)) begin
                    r = rand_req(REQ_BOOK);
                    if ($urandom_range(1))
                        r.coef = {{5{r.coef[10]}}, r.coef[10:0]};
                    push_request(r, 1'b0, '0);
                    done++;
                end
            end else if (pick < 88) begin
                // ignored kind, not counted
                repeat ($urandom_range(3, 1))
                    push_request(rand_req(REQ_SPARE), 1'b0, '0);
            end else begin
                push_request(rand_req(2'($urandom_range(2))), 1'b0, '0);
                done++;
            end
        end
    endtask

    // receiver: random idling plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm != hold_seen) begin
            hold_seen <= hold_arm;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (idle_on) begin
            m_tready <= ($urandom_range(99) >= 20);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each taken pair with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pairs.size() == 0) begin
                err_count++;
                $error("pair with nothing pending: sample_first %0d sample_second %0d",
                       $signed(m_tdata[15:0]), $signed(m_tdata[31:16]));
            end else begin
                mon_want = pending_pairs.pop_front();
                check_field("sample_first", int'($signed(mon_want.first_s)),
                            int'($signed(m_tdata[15:0])));
                check_field("sample_second", int'($signed(mon_want.second_s)),
                            int'($signed(m_tdata[31:16])));
                check_field("frame_last", int'(mon_want.frame_end), int'(m_tlast));
            end
        end
    end

    initial begin
        vad_req_t r;

        // directed table: predictor 0 is all zeros, 1 all max, 2 all min
        add_row(REQ_START, HIST_ZERO, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BYTE, 16'h00, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BYTE, 16'h7f, 0, 0, 1, 16'd7, 16'hffff, 0);
        add_row(REQ_BYTE, 16'h80, 0, 0, 1, 16'hfff8, 16'd0, 0);
        add_row(REQ_BYTE, 16'h08, 0, 0, 1, 16'd0, 16'hfff8, 0);
        add_row(REQ_BYTE, 16'hf7, 0, 0, 1, 16'hffff, 16'd7, 0);
        add_row(REQ_BYTE, 16'h00, 0, 0, 1, 16'd0, 16'd0, 0);
        add_row(REQ_BYTE, 16'h11, 0, 0, 1, 16'd1, 16'd1, 0);
        add_row(REQ_BYTE, 16'h22, 0, 0, 1, 16'd2, 16'd2, 0);
        add_row(REQ_BYTE, 16'h33, 0, 0, 1, 16'd3, 16'd3, 1);
        // header with no start, scale 15, predictor nibble wraps to 0
        add_row(REQ_BYTE, 16'hf8, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BYTE, 16'h17, 0, 0, 1, 16'h8000, 16'h8000, 0);
        add_row(REQ_BYTE, 16'hf0, 0, 0, 1, 16'h8000, 16'd0, 0);
        // start in mid-frame, saturation both ways
        add_row(REQ_START, HIST_GIVEN, 16'h7fff, 16'h7fff, 0, 0, 0, 0);
        add_row(REQ_BYTE, 16'h01, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BYTE, 16'h77, 0, 0, 1, 16'h7fff, 16'h7fff, 0);
        add_row(REQ_START, HIST_GIVEN, 16'h8000, 16'h8000, 0, 0, 0, 0);
        add_row(REQ_BYTE, 16'h01, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BYTE, 16'h77, 0, 0, 1, 16'h8000, 16'h8000, 0);
        // loop history, ignored kind, spare history source
        add_row(REQ_START, HIST_LOOP, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BYTE, 16'h93, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BYTE, 16'ha5, 0, 0, 0, 0, 0, 0);
        add_row(REQ_SPARE, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_START, HIST_SPARE, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BOOK, 16'd127, 16'h8000, 0, 0, 0, 0, 0);
        add_row(REQ_BYTE, 16'h4f, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BYTE, 16'hff, 0, 0, 0, 0, 0, 0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_loop(16'h7fff, 16'h8000);

        // fill every codebook word before any data byte
        for (int i = 0; i < BOOK_WORDS; i++) begin
            r = rand_req(REQ_BOOK);
            r.idx = 7'(i);
            if (i < 16)
                r.coef = 16'h0000;
            else if (i < 32)
                r.coef = 16'h7fff;
            else if (i < 48)
                r.coef = 16'h8000;
            else if ($urandom_range(1))
                r.coef = {{5{r.coef[10]}}, r.coef[10:0]};
            push_request(r, 1'b0, '0);
        end

        foreach (dir_rows[i])
            push_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        drain_pairs();

        // random phases, loop history rewritten between them
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_loop(16'h8000, 16'h7fff);
                2: set_loop(16'h0000, 16'h0000);
                default: set_loop(16'($urandom), 16'($urandom));
            endcase
            idle_on <= (ph != 2);
            if (ph == 1)
                hold_arm <= ~hold_arm;
            run_random(PHASE_ITEMS);
            drain_pairs();
        end

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/vad_pkg.sv
design/vad_coef_mem.sv
design/vad_lane.sv
design/vadpcm_frame_decoder.sv
design/vadpcm_frame_decoder_checker.sv
verif/tb_vadpcm_frame_decoder.sv
